/* sv/cqr_pkg.sv */
// Shared types, command codes and defaults for the circular queue with reverse.
package cqr_pkg;

  localparam int CQR_DEPTH = 16;

  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_CLR = 2'd2;
  localparam logic [1:0] CMD_REV = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] data_in;
  } cqr_in_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] data_out;
    logic [3:0]         fill_count;
    logic               is_empty;
    logic               is_full;
    logic [3:0]         head_index;
    logic [3:0]         tail_index;
  } cqr_out_t;

endpackage

/* sv/circular_queue_with_reverse.sv */
// Top level: circular FIFO of signed words with enqueue, dequeue, clear and reverse.
//
//   channel | ports                      | handshake
//   --------+----------------------------+------------------------------------------
//   input   | start, busy, in_item       | beat taken at an edge with start & !busy
//   result  | out_strobe, out_item       | one beat per command, strobe for one cycle
//
// Enqueue, clear, a failed command and the reverse of an empty queue answer in
// the cycle after acceptance and leave busy low. Dequeue holds busy in S_DEQ
// while the slot memory read returns, then answers from the result register. Reverse
// of L words walks S_RA (L reads into the scratch memory), S_RDR (drain), S_RB
// (L writes back) and S_RFIN (finish); one port per memory sets this pace.
// Reset clears the pointers and the controller; the memories need no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
module circular_queue_with_reverse
  import cqr_pkg::*;
#(
  parameter int DEPTH = CQR_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cqr_in_t  in_item,
  output logic     out_strobe,
  output cqr_out_t out_item
);

  localparam int AW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEQ  = 3'd1;
  localparam logic [2:0] S_RA   = 3'd2;
  localparam logic [2:0] S_RDR  = 3'd3;
  localparam logic [2:0] S_RB   = 3'd4;
  localparam logic [2:0] S_RFIN = 3'd5;

  // Advance a slot pointer round the ring.
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Occupancy from head and tail, modulo DEPTH.
  function automatic logic [AW-1:0] fill_of(input logic [AW-1:0] h, input logic [AW-1:0] t);
    logic [AW:0] d;
    d = {1'b0, t} - {1'b0, h};
    if (t < h) begin
      d = d + (AW+1)'(DEPTH);
    end
    fill_of = d[AW-1:0];
  endfunction

  // Keep the low four bits of a pointer-sized value.
  function automatic logic [3:0] low4(input logic [AW-1:0] v);
    logic [AW+3:0] w;
    w = {4'b0000, v};
    low4 = w[3:0];
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;     // walk position during reverse
  logic [AW-1:0] len_r, len_nxt;     // word count captured at reverse start
  logic [AW-1:0] rp_r, rp_nxt;       // slot read pointer, copy-out phase
  logic [AW-1:0] wp_r, wp_nxt;       // slot write pointer, write-back phase
  logic          pend_a_r;           // scratch write due from last slot read
  logic [AW-1:0] pidx_r;
  logic          pend_b_r;           // slot write due from last scratch read
  logic          out_strobe_r;
  cqr_out_t      out_item_r;

  logic          accept;
  logic          q_empty, q_full;
  logic          res_vld, res_status;
  logic [31:0]   res_data;
  cqr_out_t      out_nxt;

  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [31:0]   m_wdata, m_rdata;
  logic [AW-1:0] t_raddr;
  logic [31:0]   t_rdata;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start & ~busy;
  assign q_empty = (head_r == tail_r);
  assign q_full  = (wrap_inc(tail_r) == head_r);
  assign t_raddr = len_r - cnt_r - 1'b1;

  // Slot store: enqueue and write-back write it, dequeue and copy-out read it.
  // Commands are serialised by busy, so no read whose data is used meets a write to
  // the same slot in one cycle and no forwarding is needed.
  cqr_ram #(.DEPTH(DEPTH), .AW(AW), .DW(32)) u_slot_ram (
    .clk    (clk),
    .we     (m_we),
    .waddr  (m_waddr),
    .wdata  (m_wdata),
    .raddr  (m_raddr),
    .rd_data(m_rdata)
  );

  // Scratch store: holds the old contents in queue order during a reverse.
  cqr_ram #(.DEPTH(DEPTH), .AW(AW), .DW(32)) u_scratch_ram (
    .clk    (clk),
    .we     (pend_a_r),
    .waddr  (pidx_r),
    .wdata  (m_rdata),
    .raddr  (t_raddr),
    .rd_data(t_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    res_vld    = 1'b0;
    res_status = 1'b0;
    res_data   = '0;
    m_we       = 1'b0;
    m_waddr    = tail_r;
    m_wdata    = in_item.data_in;
    m_raddr    = rp_r;

    // Write back the scratch word read in the previous cycle, newest first.
    if (pend_b_r) begin
      m_we    = 1'b1;
      m_waddr = wp_r;
      m_wdata = t_rdata;
      wp_nxt  = wrap_inc(wp_r);
    end

    case (state_r)
      S_IDLE: begin
        m_raddr = head_r;
        if (accept) begin
          case (in_item.command)
            CMD_ENQ: begin
              res_vld = 1'b1;
              if (q_full) begin
                res_status = 1'b1;
              end else begin
                m_we     = 1'b1;
                m_waddr  = tail_r;
                m_wdata  = in_item.data_in;
                tail_nxt = wrap_inc(tail_r);
              end
            end
            CMD_DEQ: begin
              if (q_empty) begin
                res_vld    = 1'b1;
                res_status = 1'b1;
              end else begin
                head_nxt  = wrap_inc(head_r);
                state_nxt = S_DEQ;
              end
            end
            CMD_CLR: begin
              res_vld  = 1'b1;
              head_nxt = '0;
              tail_nxt = '0;
            end
            CMD_REV: begin
              if (q_empty) begin
                res_vld  = 1'b1;
                head_nxt = tail_r;
              end else begin
                len_nxt   = fill_of(head_r, tail_r);
                cnt_nxt   = '0;
                rp_nxt    = head_r;
                wp_nxt    = tail_r;
                state_nxt = S_RA;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        res_vld   = 1'b1;
        res_data  = m_rdata;
        state_nxt = S_IDLE;
      end
      S_RA: begin
        rp_nxt = wrap_inc(rp_r);
        if (cnt_r == len_r - 1'b1) begin
          cnt_nxt   = '0;
          state_nxt = S_RDR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RDR: begin
        state_nxt = S_RB;
      end
      S_RB: begin
        if (cnt_r == len_r - 1'b1) begin
          state_nxt = S_RFIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RFIN: begin
        res_vld   = 1'b1;
        head_nxt  = tail_r;
        tail_nxt  = wrap_inc(wp_r);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result beat, built from the pointers as they stand after the command.
  always_comb begin
    out_nxt.status     = res_status;
    out_nxt.data_out   = res_data;
    out_nxt.fill_count = low4(fill_of(head_nxt, tail_nxt));
    out_nxt.is_empty   = (head_nxt == tail_nxt);
    out_nxt.is_full    = (wrap_inc(tail_nxt) == head_nxt);
    out_nxt.head_index = low4(head_nxt);
    out_nxt.tail_index = low4(tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      len_r        <= '0;
      rp_r         <= '0;
      wp_r         <= '0;
      pend_a_r     <= 1'b0;
      pend_b_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
      len_r        <= len_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      pend_a_r     <= (state_r == S_RA);
      pend_b_r     <= (state_r == S_RB);
      out_strobe_r <= res_vld;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    pidx_r <= cnt_r;
    if (res_vld) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // A dequeue that reached the read state always delivers its beat next.
  a_deq_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ) |=> out_strobe)
    else $error("dequeue read did not produce a result beat");

  // Reverse keeps the number of stored words.
  a_rev_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RFIN) |=> (fill_of(head_r, tail_r) == $past(len_r)))
    else $error("reverse changed the fill count");

  // Enqueue into a full queue reports an error on the next beat.
  a_enq_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.command == CMD_ENQ) && q_full) |=> (out_strobe && out_item.status))
    else $error("enqueue when full not flagged");

  // Copy-out drains before the scratch store is read back.
  a_scratch_drained: assert property (@(posedge clk) disable iff (!rst_n)
    pend_a_r |-> (state_r != S_RB))
    else $error("scratch write overlaps write-back read");

endmodule

/* sv/cqr_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module cqr_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule
